FILE: src/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared codes and constants of the linear probing hash table: slot marks,
// request actions, result status codes and the home slot divider step size.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // slot mark codes
  localparam logic [1:0] MARK_NEVER    = 2'd0;
  localparam logic [1:0] MARK_OCCUPIED = 2'd1;
  localparam logic [1:0] MARK_TOMB     = 2'd2;

  // request actions; the unused code is answered as a miss
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // result status codes
  localparam logic [1:0] STS_NEW       = 2'd0;
  localparam logic [1:0] STS_DONE      = 2'd1;
  localparam logic [1:0] STS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STS_FULL      = 2'd3;

  // key bits retired per cycle by the home slot unit
  localparam int unsigned RADIX_BITS = 4;

  // field widths of the ports
  localparam int unsigned KEY_PORT_BITS   = 32;
  localparam int unsigned VALUE_PORT_BITS = 32;
  localparam int unsigned COUNT_PORT_BITS = 11;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_HASH   = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

endpackage

FILE: src/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/lpht_mod.sv
// ----------------------------------------------------------------------------
// lpht_mod
// Home slot unit: key modulo SLOTS. A power of two table registers the low
// key bits; any other size runs a restoring remainder RADIX_BITS key bits per
// cycle, most significant bits first.
// ----------------------------------------------------------------------------
module lpht_mod import lpht_pkg::*; #(
  parameter int unsigned SLOTS    = 1024,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [KEY_BITS-1:0]      key,
  output logic                     done,
  output logic [$clog2(SLOTS)-1:0] home
);

  localparam int unsigned IW = $clog2(SLOTS);

  generate
    if ((SLOTS & (SLOTS - 1)) == 0) begin : g_pow2
      logic [IW+KEY_BITS-1:0] key_ext;

      assign key_ext = {{IW{1'b0}}, key};

      // low key bits are the home slot
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          home <= key_ext[IW-1:0];
        end
      end
    end else begin : g_div
      localparam int unsigned STEPS = (KEY_BITS + RADIX_BITS - 1) / RADIX_BITS;
      localparam int unsigned PW    = STEPS * RADIX_BITS;
      localparam int unsigned RW    = IW + 1;
      localparam int unsigned CW    = $clog2(STEPS + 1);
      localparam logic [RW-1:0] SLOTS_R = RW'(SLOTS);
      localparam logic [CW-1:0] LAST_STEP = CW'(STEPS - 1);

      logic [PW-1:0] shreg;
      logic [RW-1:0] rem;
      logic [RW-1:0] rem_next;
      logic [CW-1:0] cnt;
      logic          busy;

      // one digit of restoring remainder
      always_comb begin
        logic [RW-1:0] rr;
        rr = rem;
        for (int i = 0; i < RADIX_BITS; i++) begin
          rr = {rr[RW-2:0], shreg[PW-1-i]};
          if (rr >= SLOTS_R) begin
            rr = rr - SLOTS_R;
          end
        end
        rem_next = rr;
      end

      // step control
      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          done <= 1'b0;
          cnt  <= '0;
        end else begin
          done <= 1'b0;
          if (start) begin
            busy <= 1'b1;
            cnt  <= '0;
          end else if (busy) begin
            cnt <= cnt + 1'b1;
            if (cnt == LAST_STEP) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        end
      end

      // datapath
      always_ff @(posedge clk) begin
        if (start) begin
          shreg <= PW'(key);
          rem   <= '0;
        end else if (busy) begin
          shreg <= {shreg[PW-RADIX_BITS-1:0], {RADIX_BITS{1'b0}}};
          rem   <= rem_next;
        end
      end

      assign home = rem[IW-1:0];
    end
  endgenerate

endmodule

FILE: src/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing hash table with linear probing; insert, lookup, remove.
// ----------------------------------------------------------------------------
// One request at a time. After reset the table runs a clearing pass that
// marks every slot never used; no word is taken during it. A request then
// computes its home slot (the low key bits for a power of two table, a
// restoring remainder otherwise), probes slots one per cycle through the
// read port of the slot RAM, then writes back where the action needs it and
// posts the result; the unused action code goes straight to the result as a
// miss. A new word is accepted while the previous result still waits on the
// output.
// ----------------------------------------------------------------------------
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int unsigned SLOTS      = 1024,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] value_out,
  output logic [10:0] entry_count
);

  localparam int unsigned KW = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
  localparam int unsigned VW = (VALUE_BITS < VALUE_PORT_BITS) ? VALUE_BITS : VALUE_PORT_BITS;
  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned DW = 2 + KW + VW;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  state_t state;

  logic [IW-1:0] clr_addr;
  logic [1:0]    act;
  logic [KW-1:0] key_r;
  logic [VW-1:0] val_r;
  logic [IW-1:0] cur;
  logic [IW-1:0] chk_idx;
  logic          chk_valid;
  logic [IW-1:0] n;
  logic          free_found;
  logic [IW-1:0] free_at;
  logic          found;
  logic [IW-1:0] hit_idx;
  logic [VW-1:0] hit_val;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [1:0]    status_next;
  logic [VW-1:0] vout_next;
  logic [VW-1:0] vout_r;

  logic          in_take;
  logic          mod_start;
  logic          mod_done;
  logic [IW-1:0] home;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [DW-1:0] ram_rdata;

  logic [1:0]    rd_mark;
  logic [KW-1:0] rd_key;
  logic [VW-1:0] rd_val;
  logic          rd_occ;
  logic          rd_match;
  logic          rd_stop;

  logic          fin_go;
  logic          fin_wr;
  logic [IW-1:0] fin_addr;
  logic [1:0]    fin_mark;

  logic [CW+COUNT_PORT_BITS-1:0] count_ext;
  logic [VW+VALUE_PORT_BITS-1:0] vout_ext;

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign mod_start = in_take && (action != ACT_UNUSED);

  // home slot unit
  lpht_mod #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KW)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .key   (key[KW-1:0]),
    .done  (mod_done),
    .home  (home)
  );

  // slot store: mark, key, value
  lpht_ram #(
    .WIDTH (DW),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur),
    .rdata (ram_rdata)
  );

  // probe evaluation of the slot read last cycle
  assign rd_mark  = ram_rdata[DW-1:DW-2];
  assign rd_key   = ram_rdata[KW+VW-1:VW];
  assign rd_val   = ram_rdata[VW-1:0];
  assign rd_occ   = (rd_mark == MARK_OCCUPIED);
  assign rd_match = rd_occ && (rd_key == key_r);
  assign rd_stop  = (!rd_occ && (rd_mark == MARK_NEVER)) || (n == LAST);

  // finish decision
  assign fin_go = (state == ST_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    fin_wr      = 1'b0;
    fin_addr    = hit_idx;
    fin_mark    = MARK_OCCUPIED;
    status_next = STS_NOT_FOUND;
    vout_next   = '0;
    count_next  = count;
    unique case (act)
      ACT_INSERT: begin
        if (found) begin
          fin_wr      = 1'b1;
          status_next = STS_DONE;
        end else if (free_found) begin
          fin_wr      = 1'b1;
          fin_addr    = free_at;
          status_next = STS_NEW;
          count_next  = count + 1'b1;
        end else begin
          status_next = STS_FULL;
        end
      end
      ACT_LOOKUP: begin
        if (found) begin
          vout_next   = hit_val;
          status_next = STS_DONE;
        end
      end
      ACT_REMOVE: begin
        if (found) begin
          fin_wr      = 1'b1;
          fin_mark    = MARK_TOMB;
          status_next = STS_DONE;
          if (count != '0) begin
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
        status_next = STS_NOT_FOUND;
      end
    endcase
  end

  // ram write port: clearing pass or write back
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = fin_go && fin_wr;
      ram_waddr = fin_addr;
      ram_wdata = {fin_mark, key_r, val_r};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_take) begin
            state <= (action == ACT_UNUSED) ? ST_FINISH : ST_HASH;
          end
        end
        ST_HASH: begin
          chk_valid <= 1'b0;
          if (mod_done) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          chk_valid <= 1'b1;
          if (chk_valid && (rd_match || rd_stop)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fin_go) begin
            count <= count_next;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request and probe registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      act        <= action;
      key_r      <= key[KW-1:0];
      val_r      <= value[VW-1:0];
      found      <= 1'b0;
      free_found <= 1'b0;
    end
    if ((state == ST_HASH) && mod_done) begin
      cur <= home;
      n   <= '0;
    end
    if (state == ST_SCAN) begin
      cur     <= (cur == LAST) ? '0 : cur + 1'b1;
      chk_idx <= cur;
      if (chk_valid) begin
        n <= n + 1'b1;
        if (rd_match) begin
          found   <= 1'b1;
          hit_idx <= chk_idx;
          hit_val <= rd_val;
        end else if (!rd_occ && !free_found) begin
          free_found <= 1'b1;
          free_at    <= chk_idx;
        end
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (fin_go) begin
      status <= status_next;
      vout_r <= vout_next;
    end
  end

  assign vout_ext    = {{VALUE_PORT_BITS{1'b0}}, vout_r};
  assign value_out   = vout_ext[VALUE_PORT_BITS-1:0];
  assign count_ext   = {{COUNT_PORT_BITS{1'b0}}, count};
  assign entry_count = count_ext[COUNT_PORT_BITS-1:0];

endmodule

FILE: tb/tb_linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Drives insert, lookup, remove and unused-code words into the hash table and
// checks every reply against a shadow copy of the slot store kept in a
// scoreboard. The run has a directed opening, then random traffic over a
// small clustered key pool under changing idle and stall patterns.
// ----------------------------------------------------------------------------
import lpht_pkg::*;

localparam int unsigned TABLE_SLOTS = 1024;
localparam int unsigned POOL_KEYS   = 48;

typedef struct packed {
  logic [1:0]  status;
  logic [31:0] value_out;
  logic [10:0] entry_count;
} table_reply_t;

// shadow hash table plus the queue of replies still owed by the block
class hash_table_scoreboard;
  logic [1:0]   mark [TABLE_SLOTS];
  logic [31:0]  stored_key [TABLE_SLOTS];
  logic [31:0]  stored_value [TABLE_SLOTS];
  int unsigned  live_entries;
  table_reply_t replies_due[$];
  int           mismatches;

  function new();
    for (int s = 0; s < TABLE_SLOTS; s++) mark[s] = MARK_NEVER;
    live_entries = 0;
    mismatches   = 0;
  endfunction

  // apply one accepted word to the shadow table and queue its reply
  function void apply_request(logic [1:0] act, logic [31:0] k, logic [31:0] v);
    int unsigned  slot;
    int unsigned  free_slot;
    int unsigned  hit_slot;
    bit           hit;
    table_reply_t r;
    r.status    = STS_NOT_FOUND;
    r.value_out = '0;
    hit         = 1'b0;
    hit_slot    = 0;
    free_slot   = TABLE_SLOTS;
    if (act != ACT_UNUSED) begin
      // probe from home slot: stop on match, never-used slot or full wrap
      slot = k % TABLE_SLOTS;
      for (int n = 0; n < TABLE_SLOTS; n++) begin
        if (mark[slot] == MARK_OCCUPIED) begin
          if (stored_key[slot] == k) begin
            hit      = 1'b1;
            hit_slot = slot;
            break;
          end
        end else begin
          if (free_slot == TABLE_SLOTS) free_slot = slot;
          if (mark[slot] == MARK_NEVER) break;
        end
        slot = (slot + 1) % TABLE_SLOTS;
      end
    end
    case (act)
      ACT_INSERT: begin
        if (hit) begin
          stored_value[hit_slot] = v;
          r.status = STS_DONE;
        end else if (free_slot < TABLE_SLOTS) begin
          stored_key[free_slot]   = k;
          stored_value[free_slot] = v;
          mark[free_slot]         = MARK_OCCUPIED;
          live_entries++;
          r.status = STS_NEW;
        end else begin
          r.status = STS_FULL;
        end
      end
      ACT_LOOKUP: begin
        if (hit) begin
          r.value_out = stored_value[hit_slot];
          r.status    = STS_DONE;
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          mark[hit_slot] = MARK_TOMB;
          if (live_entries > 0) live_entries--;
          r.status = STS_DONE;
        end
      end
      default: ;
    endcase
    r.entry_count = live_entries[10:0];
    replies_due = {replies_due, r};
  endfunction

  task report_mismatch(string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // compare one accepted reply word with the oldest one owed
  task check_reply(logic [1:0] st, logic [31:0] vout, logic [10:0] cnt);
    table_reply_t want;
    if (replies_due.size() == 0) begin
      report_mismatch("reply word with no request pending");
      return;
    end
    want = replies_due.pop_front();
    if (st !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", st, want.status));
    if (vout !== want.value_out)
      report_mismatch($sformatf("value_out got %h want %h", vout, want.value_out));
    if (cnt !== want.entry_count)
      report_mismatch($sformatf("entry_count got %0d want %0d", cnt, want.entry_count));
  endtask
endclass

module tb_linear_probe_hash_table;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic [31:0] key;
  logic [31:0] value;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] value_out;
  logic [10:0] entry_count;

  hash_table_scoreboard board;
  logic [31:0]          key_pool [POOL_KEYS];
  int                   sender_idle_pct;
  int                   stall_pct;

  linear_probe_hash_table dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .value_out   (value_out),
    .entry_count (entry_count)
  );

  always #5 clk = ~clk;

  // reply side: take accepted words, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      board.check_reply(status, value_out, entry_count);
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // present one request word and hold it until taken
  task automatic send_word(input logic [1:0] act, input logic [31:0] k,
                           input logic [31:0] v);
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    key      <= k;
    value    <= v;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.apply_request(act, k, v);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, POOL_KEYS - 1)];
  endfunction

  // random traffic over the clustered pool; ignored action codes not counted
  task automatic random_traffic(input int count);
    int         done;
    int         roll;
    logic [1:0] act;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 5)       act = ACT_UNUSED;
      else if (roll < 45) act = ACT_INSERT;
      else if (roll < 80) act = ACT_LOOKUP;
      else                act = ACT_REMOVE;
      send_word(act, pick_key(), $urandom);
      if (act != ACT_UNUSED) done++;
    end
  endtask

  initial begin
    board           = new();
    rst             = 1'b1;
    in_valid        = 1'b0;
    action          = ACT_INSERT;
    key             = '0;
    value           = '0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    // most pool keys share a few home slots so probe chains grow
    for (int i = 0; i < POOL_KEYS; i++) begin
      if (i < 40) key_pool[i] = {22'($urandom), 10'($urandom_range(0, 23))};
      else        key_pool[i] = $urandom;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, collisions, wrap, tombstones, ignored code
    send_word(ACT_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_word(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(ACT_INSERT, 32'd1024, 32'hA5A5_A5A5);
    send_word(ACT_INSERT, 32'h0000_0000, 32'h5A5A_5A5A);
    send_word(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_word(ACT_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_word(ACT_LOOKUP, 32'd1024, 32'h0000_0000);
    send_word(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_word(ACT_INSERT, 32'd2048, 32'h0000_0001);
    send_word(ACT_INSERT, 32'd2047, 32'h0000_0002);
    send_word(ACT_LOOKUP, 32'd2047, 32'h0000_0000);
    send_word(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(ACT_LOOKUP, 32'd2047, 32'h0000_0000);
    send_word(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(ACT_UNUSED, 32'd2047, 32'hFFFF_FFFF);
    send_word(ACT_LOOKUP, 32'd2047, 32'h0000_0000);
    // replace must win over the earlier tombstone on the chain
    send_word(ACT_INSERT, 32'd2047, 32'h0000_0003);
    send_word(ACT_LOOKUP, 32'd2047, 32'h0000_0000);
    send_word(ACT_REMOVE, 32'd1024, 32'h0000_0000);
    send_word(ACT_LOOKUP, 32'd2048, 32'h0000_0000);

    // random traffic under four idle and stall patterns
    random_traffic(185);
    sender_idle_pct = 61;
    random_traffic(185);
    sender_idle_pct = 0;
    stall_pct       = 61;
    random_traffic(185);
    sender_idle_pct = 32;
    stall_pct       = 32;
    random_traffic(185);

    in_valid <= 1'b0;
    while (board.replies_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
